>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define SITDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet while reset is held
`define SITDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/sitda_pkg.sv
// package: constants, types and the double-dabble step of the integer-to-text block
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CharW      = 8;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdW       = NumDigits * DigitW;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned NumSteps   = ValueW / BitsPerStep;
  localparam int unsigned StepW      = $clog2(NumSteps);

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture sign and magnitude, clear digits
    logic step;     // fold BitsPerStep magnitude bits into the digits
    logic lead;     // locate the leading digit, arm the sign
    logic advance;  // current character taken
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;     // current character ends the text
  } dp_sts_t;

  // one double-dabble bit: add 3 to every digit of 5 or more, then shift in
  function automatic logic [BcdW-1:0] dd_shift(input logic [BcdW-1:0] b,
                                               input logic            bit_in);
    logic [BcdW-1:0] a;
    a = b;
    for (int d = 0; d < NumDigits; d++) begin
      if (a[d*DigitW +: DigitW] >= 4'd5) begin
        a[d*DigitW +: DigitW] = a[d*DigitW +: DigitW] + 4'd3;
      end
    end
    return {a[BcdW-2:0], bit_in};
  endfunction

endpackage

>>> hw/rtl/sitda_if.sv
// valid/ready channel interfaces for the value input and the character output
`timescale 1ns / 1ps

interface sitda_value_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

>>> hw/rtl/sitda_datapath.sv
// datapath: magnitude, bcd digit register, leading digit index and character select
`timescale 1ns / 1ps

module sitda_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sitda_pkg::dp_cmd_t         cmd_i,
  input  logic [31:0]                value_i,
  output sitda_pkg::dp_sts_t         sts_o,
  output logic [7:0]                 text_char_o,
  output logic                       final_char_o
);

  logic [sitda_pkg::ValueW-1:0] bin_q, bin_d;
  logic [sitda_pkg::BcdW-1:0]   bcd_q, bcd_d;
  logic                         neg_q, neg_d;
  logic                         sign_q, sign_d;
  logic [sitda_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [sitda_pkg::ValueW-1:0] mag;
  logic [sitda_pkg::BcdW-1:0]   bcd_step;
  logic [sitda_pkg::IdxW-1:0]   lead_idx;
  logic [sitda_pkg::DigitW-1:0] digits [sitda_pkg::NumDigits];
  logic [sitda_pkg::DigitW-1:0] cur_digit;

  // two's complement magnitude, the most negative value wraps to 2^31 unsigned
  assign mag = value_i[sitda_pkg::ValueW-1] ? (~value_i + 32'd1) : value_i;

  always_comb begin
    bcd_step = bcd_q;
    for (int k = 0; k < sitda_pkg::BitsPerStep; k++) begin
      bcd_step = sitda_pkg::dd_shift(bcd_step, bin_q[sitda_pkg::ValueW-1-k]);
    end
  end

  always_comb begin
    for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
      digits[d] = bcd_q[d*sitda_pkg::DigitW +: sitda_pkg::DigitW];
    end
  end

  // highest nonzero digit, zero itself keeps index 0
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
      if (digits[d] != '0) begin
        lead_idx = sitda_pkg::IdxW'(d);
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    if (cmd_i.load) begin
      bin_d = mag;
      bcd_d = '0;
      neg_d = value_i[sitda_pkg::ValueW-1];
    end else if (cmd_i.step) begin
      bin_d = {bin_q[sitda_pkg::ValueW-1-sitda_pkg::BitsPerStep:0],
               {sitda_pkg::BitsPerStep{1'b0}}};
      bcd_d = bcd_step;
    end else if (cmd_i.lead) begin
      idx_d  = lead_idx;
      sign_d = neg_q;
    end else if (cmd_i.advance) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q != '0) begin
        idx_d = idx_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign cur_digit    = digits[idx_q];
  assign text_char_o  = sign_q ? sitda_pkg::CharMinus
                               : sitda_pkg::CharZero + {4'b0000, cur_digit};
  assign final_char_o = !sign_q && (idx_q == '0);
  assign sts_o.last   = final_char_o;

endmodule

>>> hw/rtl/sitda_ctrl.sv
// controller: state machine sequencing load, conversion passes and character beats
`timescale 1ns / 1ps

module sitda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sitda_pkg::dp_sts_t  sts_i,
  output sitda_pkg::dp_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StLead = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [sitda_pkg::StepW-1:0] step_q, step_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);

  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.step    = (state_q == StConv);
  assign cmd_o.lead    = (state_q == StLead);
  assign cmd_o.advance = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        step_d = '0;
        if (cmd_o.load) begin
          state_d = StConv;
        end
      end
      StConv: begin
        step_d = step_q + 1'b1;
        if (step_q == sitda_pkg::StepW'(sitda_pkg::NumSteps - 1)) begin
          state_d = StLead;
        end
      end
      StLead: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (cmd_o.advance && sts_i.last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii character stream
//
// in_i carries one signed 32-bit value per beat; out_o returns its decimal
// text one character per beat, most significant first, with a leading '-'
// for negative values and final_char set on the last character. zero gives
// a single '0', the most negative value gives "-2147483648".
// one value is in flight at a time: in_i.ready is high only while idle.
// after an input beat the magnitude goes through 8 double-dabble passes of
// 4 bits each, then the lead state finds the leading digit and arms the sign,
// after which out_o offers the first character.
// an item has 1 to 11 characters; with the sink always ready out_o gives
// one character per cycle, and while out_o.ready is low it waits.
// out_o.valid holds with a steady payload while out_o.ready is low; the
// block simply waits and takes no new value until the last beat is taken.
// reset (rst_ni low, asynchronous) returns the controller to idle and drops
// any value in flight; no state carries between values.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic          clk_i,
  input  logic          rst_ni,
  sitda_value_if.sink   in_i,
  sitda_char_if.source  out_o
);

  sitda_pkg::dp_cmd_t cmd;
  sitda_pkg::dp_sts_t sts;

  // sequencing of load, passes, leading digit scan and character beats
  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // magnitude, bcd digits and the character mux
  sitda_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (in_i.value),
    .sts_o        (sts),
    .text_char_o  (out_o.text_char),
    .final_char_o (out_o.final_char)
  );

endmodule

>>> hw/rtl/sitda_checker.sv
// checker: port-level assertions of the integer-to-text block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sitda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] text_char_i,
  input logic       final_char_i
);

  logic char_ok;

  // minus sign or a decimal digit
  assign char_ok = text_char_i inside {sitda_pkg::CharMinus,
                                       [sitda_pkg::CharZero : sitda_pkg::CharZero + 8'd9]};

  `SITDA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SITDA_ASSERT_IMP(a_one_in_flight, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `SITDA_ASSERT_IMP(a_char_set, clk_i, rst_ni, out_valid_i, char_ok)
  `SITDA_ASSERT_NXT(a_final_ends, clk_i, rst_ni, out_valid_i && out_ready_i && final_char_i, !out_valid_i)
  `SITDA_ASSERT_NXT(a_no_early_out, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .text_char_i  (out_o.text_char),
  .final_char_i (out_o.final_char)
);
